### rtl/spca_pkg.sv
// Package for the seasonal palette color adjust block: register codes, season codes,
// fixed-point constants and the night-light color table.
// No dependencies; imported by the top level, the checker and the testbench.
`timescale 1ns / 1ps

package spca_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned GAIN_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEASON       = 3'd0,
    CFG_GAIN_RED     = 3'd1,
    CFG_GAIN_GREEN   = 3'd2,
    CFG_GAIN_BLUE    = 3'd3,
    CFG_LIGHT_LEVEL  = 3'd4,
    CFG_NIGHT_VISION = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEAS_SUMMER = 2'd0,
    SEAS_AUTUMN = 2'd1,
    SEAS_WINTER = 2'd2,
    SEAS_SPRING = 2'd3
  } season_t;

  // Hue is in degrees with 7 fraction bits, saturation Q1.16, value 8.8.
  localparam logic [15:0] HUE_60    = 16'd7680;
  localparam logic [16:0] HUE_360   = 17'd46080;
  localparam logic [16:0] S_ONE     = 17'd65536;
  localparam logic [15:0] V_MAX     = 16'd65280;
  localparam logic [28:0] FAC_ONE   = 29'd503316480;
  localparam logic [16:0] GAIN_ONE  = 17'd65536;
  localparam logic [16:0] LIGHT_HALF = 17'd32768;
  localparam logic [7:0]  NIGHT_BASE = 8'd252;

  // Reciprocals ceil(2^32 / d); exact for numerators below 2^22.
  localparam logic [29:0] RCP_5   = 30'd858993460;
  localparam logic [29:0] RCP_10  = 30'd429496730;
  localparam logic [29:0] RCP_20  = 30'd214748365;
  localparam logic [29:0] RCP_100 = 30'd42949673;

  // Reciprocal of 15 with a 19-bit shift; exact for values below 4096.
  localparam logic [15:0] RCP_15 = 16'h8889;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  function automatic rgb_t night_color(input logic [1:0] sel);
    rgb_t c;
    unique case (sel)
      2'd0: c = '{red: 8'd115, green: 8'd171, blue: 8'd155};
      2'd1: c = '{red: 8'd183, green: 8'd127, blue: 8'd83};
      2'd2: c = '{red: 8'd171, green: 8'd179, blue: 8'd139};
      default: c = '{red: 8'd171, green: 8'd171, blue: 8'd171};
    endcase
    return c;
  endfunction

endpackage

### rtl/seasonal_palette_color_adjust.sv
// Top level of the seasonal palette color adjust block: HSV analysis, season rules,
// HSV to RGB, light gain and night lights. Depends on spca_pkg and spca_div.
`timescale 1ns / 1ps

// Usage:
//   The input channel (in_valid/in_ready) carries one palette entry per transaction:
//   entry index and 8-bit red, green and blue. The output channel (out_valid/out_ready)
//   returns one adjusted entry per transaction, in order.
//   The cfg_ port writes a register (season, three gains, light level, night vision)
//   at any edge where cfg_wr_en is high; write it only while the block is empty.
//   The pipeline has 17 divider stages, one bit of saturation and hue quotient each,
//   then seven stages for the season rules, the reciprocal multiplies, the HSV to RGB
//   products, and gain.
//   Throughput is one entry per cycle. The whole pipeline advances together; when the
//   receiver holds out_ready low with a result waiting, in_ready drops and every stage
//   holds, so nothing is lost or repeated.
//   Synchronous reset clears all valid bits and loads season summer, gains of 1.0,
//   full light level and night vision off.

module seasonal_palette_color_adjust (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [7:0]                           in_entry_index,
  input  logic [7:0]                           in_red,
  input  logic [7:0]                           in_green,
  input  logic [7:0]                           in_blue,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [7:0]                           out_index_out,
  output logic [7:0]                           out_lit_red,
  output logic [7:0]                           out_lit_green,
  output logic [7:0]                           out_lit_blue,
  input  logic                                 cfg_wr_en,
  input  logic [spca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spca_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import spca_pkg::*;

  localparam int unsigned QW = 17;

  typedef struct packed {
    logic [7:0] idx;
    rgb_t       rgb;
    logic [1:0] base_sel;
    logic [7:0] mx;
    logic       hok;
  } side_t;

  // ---------------- configuration ----------------
  season_t     season_r;
  logic [16:0] gain_red_r, gain_green_r, gain_blue_r, light_level_r;
  logic        night_vision_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      season_r       <= SEAS_SUMMER;
      gain_red_r     <= GAIN_ONE;
      gain_green_r   <= GAIN_ONE;
      gain_blue_r    <= GAIN_ONE;
      light_level_r  <= GAIN_ONE;
      night_vision_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SEASON:       season_r       <= season_t'(cfg_data[1:0]);
        CFG_GAIN_RED:     gain_red_r     <= cfg_data;
        CFG_GAIN_GREEN:   gain_green_r   <= cfg_data;
        CFG_GAIN_BLUE:    gain_blue_r    <= cfg_data;
        CFG_LIGHT_LEVEL:  light_level_r  <= cfg_data;
        CFG_NIGHT_VISION: night_vision_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline enable ----------------
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // ---------------- analysis into the dividers ----------------
  logic [7:0]  mx, mn, delta, a_val, c_val, mag;
  logic [1:0]  base_sel;
  logic        hok_in, neg_in;
  logic [24:0] num_s, num_h;
  side_t       side_in;

  always_comb begin
    mx = (in_red > in_green) ? in_red : in_green;
    if (in_blue > mx) mx = in_blue;
    mn = (in_red < in_green) ? in_red : in_green;
    if (in_blue < mn) mn = in_blue;
    delta  = mx - mn;
    hok_in = (delta != 8'd0);
    priority if (in_red == mx) begin
      base_sel = 2'd0; a_val = in_green; c_val = in_blue;
    end else if (in_green == mx) begin
      base_sel = 2'd1; a_val = in_blue; c_val = in_red;
    end else begin
      base_sel = 2'd2; a_val = in_red; c_val = in_green;
    end
    neg_in = (a_val < c_val);
    mag    = neg_in ? (c_val - a_val) : (a_val - c_val);
    num_s  = {1'b0, delta, 16'h0000} + 25'(mx[7:1]);
    num_h  = 25'(mag) * 25'(HUE_60) + 25'(delta[7:1]);
    side_in = '{idx: in_entry_index,
                rgb: '{red: in_red, green: in_green, blue: in_blue},
                base_sel: base_sel, mx: mx, hok: hok_in};
  end

  logic        dv_s, dv_h;
  logic [16:0] q_s, q_h;
  logic [$bits(side_t)-1:0] side_bits;
  logic        neg_d;
  side_t       side_d;

  spca_div #(.QW(QW), .DW(8), .SW($bits(side_t))) u_div_sat (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(in_valid),
    .num_i(num_s), .den_i(mx), .side_i(side_in),
    .vld_o(dv_s), .quot_o(q_s), .side_o(side_bits)
  );

  spca_div #(.QW(QW), .DW(8), .SW(1)) u_div_hue (
    .clk(clk), .rst_n(rst_n), .en_i(en), .vld_i(in_valid),
    .num_i(num_h), .den_i(delta), .side_i(neg_in),
    .vld_o(dv_h), .quot_o(q_h), .side_o(neg_d)
  );

  assign side_d = side_t'(side_bits);

  // ---------------- stage A: assemble HSV ----------------
  logic        va_r;
  logic [15:0] ha_r, va_v_r;
  logic [16:0] sa_r;
  logic        hoka_r;
  logic [7:0]  idxa_r;
  rgb_t        rgba_r;
  logic [15:0] base128, h_nxt;
  logic [12:0] part;

  always_comb begin
    part = q_h[12:0];
    unique case (side_d.base_sel)
      2'd0:    base128 = 16'd0;
      2'd1:    base128 = 16'd15360;
      default: base128 = 16'd30720;
    endcase
    priority if (!side_d.hok) begin
      h_nxt = 16'd0;
    end else if (!neg_d) begin
      h_nxt = base128 + 16'(part);
    end else if (base128 >= 16'(part)) begin
      h_nxt = base128 - 16'(part);
    end else begin
      h_nxt = 16'(HUE_360) - 16'(part);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else if (en) va_r <= dv_s;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ha_r   <= h_nxt;
      sa_r   <= side_d.hok ? q_s : 17'd0;
      va_v_r <= {side_d.mx, 8'h00};
      hoka_r <= side_d.hok;
      idxa_r <= side_d.idx;
      rgba_r <= side_d.rgb;
    end
  end

  // ---------------- stage B: season rules and reciprocal products ----------------
  logic        grey, doit, sc_h, sc_s, sc_v, zero_s, max_v, clamp_h;
  logic [21:0] hnum, snum, vnum;
  logic [29:0] srcp, vrcp;
  logic [9:0]  rgb_sum;

  always_comb begin
    grey    = (rgba_r.red == rgba_r.green) && (rgba_r.green == rgba_r.blue);
    rgb_sum = 10'(rgba_r.red) + 10'(rgba_r.green) + 10'(rgba_r.blue);
    doit = 1'b0; sc_h = 1'b0; sc_s = 1'b0; sc_v = 1'b0;
    zero_s = 1'b0; max_v = 1'b0; clamp_h = 1'b0;
    hnum = 22'(ha_r) * 22'd33 + 22'd50;
    snum = '0; vnum = '0; srcp = '0; vrcp = '0;
    unique case (season_r)
      SEAS_AUTUMN: begin
        doit    = !(grey || rgba_r.green < 8'd60 || rgb_sum > 10'd675);
        clamp_h = doit;
        if (doit) begin
          if (ha_r >= 16'd3840 && ha_r <= 16'd21120) begin
            sc_h = 1'b1;
            sc_s = 1'b1; snum = 22'(sa_r) * 22'd6 + 22'd2; srcp = RCP_5;
            sc_v = 1'b1; vnum = 22'(va_v_r) * 22'd9 + 22'd5; vrcp = RCP_10;
          end else if (!(va_v_r >= 16'd231 && sa_r >= 17'd58983)) begin
            sc_s = 1'b1; snum = 22'(sa_r) * 22'd9 + 22'd5; srcp = RCP_10;
            sc_v = 1'b1; vnum = 22'(va_v_r) * 22'd17 + 22'd10; vrcp = RCP_20;
          end
        end
      end
      SEAS_WINTER: begin
        doit = !grey || rgba_r.green < 8'd60;
        if (doit) begin
          if (hoka_r && sa_r > 17'd13107) begin
            if (ha_r >= 16'd5760 && ha_r <= 16'd19200) begin
              zero_s = 1'b1; max_v = 1'b1;
            end
          end else begin
            sc_v = 1'b1; vnum = 22'(va_v_r) * 22'd13 + 22'd5; vrcp = RCP_10;
          end
        end
      end
      SEAS_SPRING: begin
        doit = hoka_r && sa_r >= 17'd6554;
        if (doit && ha_r >= 16'd5760 && ha_r <= 16'd20480) begin
          sc_s = 1'b1; snum = 22'(sa_r) * 22'd4 + 22'd2; srcp = RCP_5;
          sc_v = 1'b1; vnum = 22'(va_v_r) * 22'd6 + 22'd2; vrcp = RCP_5;
        end
      end
      default: ;
    endcase
  end

  logic        vb_r;
  logic [51:0] ph_r, ps_r, pv_r;
  logic [15:0] hb_r, vb_v_r;
  logic [16:0] sb_r;
  logic        sch_r, scs_r, scv_r, zs_r, mv_r, ch_r, doitb_r, hokb_r;
  logic [7:0]  idxb_r;
  rgb_t        rgbb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else if (en) vb_r <= va_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ph_r    <= 52'(hnum) * 52'(RCP_100);
      ps_r    <= 52'(snum) * 52'(srcp);
      pv_r    <= 52'(vnum) * 52'(vrcp);
      hb_r    <= ha_r;
      sb_r    <= sa_r;
      vb_v_r  <= va_v_r;
      sch_r   <= sc_h;
      scs_r   <= sc_s;
      scv_r   <= sc_v;
      zs_r    <= zero_s;
      mv_r    <= max_v;
      ch_r    <= clamp_h;
      doitb_r <= doit;
      hokb_r  <= hoka_r;
      idxb_r  <= idxa_r;
      rgbb_r  <= rgba_r;
    end
  end

  // ---------------- stage C: final H, S, V ----------------
  function automatic logic [19:0] ps_dummy_free(input logic [51:0] p);
    return p[51:32];
  endfunction

  logic [19:0] h_c, s_c, v_c;

  always_comb begin
    h_c = sch_r ? (ps_dummy_free(ph_r) + 20'd1920) : 20'(hb_r);
    if (ch_r && h_c > 20'd32640) h_c = 20'd32640;
    priority if (zs_r) s_c = 20'd0;
    else if (scs_r)    s_c = ps_r[51:32];
    else               s_c = 20'(sb_r);
    if (s_c > 20'(S_ONE)) s_c = 20'(S_ONE);
    priority if (mv_r) v_c = 20'(V_MAX);
    else if (scv_r)    v_c = pv_r[51:32];
    else               v_c = 20'(vb_v_r);
    if (v_c > 20'(V_MAX)) v_c = 20'(V_MAX);
  end

  logic        vc_r;
  logic [15:0] hc_r, vc_v_r;
  logic [16:0] sc_r;
  logic        doitc_r, hokc_r;
  logic [7:0]  idxc_r;
  rgb_t        rgbc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vc_r <= 1'b0;
    else if (en) vc_r <= vb_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hc_r    <= h_c[15:0];
      sc_r    <= s_c[16:0];
      vc_v_r  <= v_c[15:0];
      doitc_r <= doitb_r;
      hokc_r  <= hokb_r;
      idxc_r  <= idxb_r;
      rgbc_r  <= rgbb_r;
    end
  end

  // ---------------- stage D: sector and factors ----------------
  logic [2:0]  sec;
  logic [15:0] sec_base;
  logic [12:0] fr, fr_inv;

  always_comb begin
    priority if (hc_r >= 16'd38400) begin sec = 3'd5; sec_base = 16'd38400; end
    else if (hc_r >= 16'd30720)     begin sec = 3'd4; sec_base = 16'd30720; end
    else if (hc_r >= 16'd23040)     begin sec = 3'd3; sec_base = 16'd23040; end
    else if (hc_r >= 16'd15360)     begin sec = 3'd2; sec_base = 16'd15360; end
    else if (hc_r >= 16'd7680)      begin sec = 3'd1; sec_base = 16'd7680; end
    else                            begin sec = 3'd0; sec_base = 16'd0; end
    fr     = 13'(hc_r - sec_base);
    fr_inv = 13'(HUE_60 - 16'(fr));
  end

  logic        vd_r;
  logic [28:0] fp_r, fq_r, ft_r;
  logic [2:0]  secd_r;
  logic        greyd_r, doitd_r;
  logic [7:0]  cvd_r;
  logic [15:0] vd_v_r;
  logic [7:0]  idxd_r;
  rgb_t        rgbd_r;
  logic [16:0] cv_sum;

  assign cv_sum = 17'(vc_v_r) + 17'd128;

  always_ff @(posedge clk) begin
    if (!rst_n) vd_r <= 1'b0;
    else if (en) vd_r <= vc_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fp_r    <= 29'(30'(S_ONE - sc_r) * 30'(HUE_60));
      fq_r    <= FAC_ONE - 29'(30'(sc_r) * 30'(fr));
      ft_r    <= FAC_ONE - 29'(30'(sc_r) * 30'(fr_inv));
      secd_r  <= sec;
      greyd_r <= !hokc_r || (sc_r == 17'd0);
      doitd_r <= doitc_r;
      cvd_r   <= cv_sum[15:8];
      vd_v_r  <= vc_v_r;
      idxd_r  <= idxc_r;
      rgbd_r  <= rgbc_r;
    end
  end

  // ---------------- stage E: value times factors ----------------
  logic        ve_r;
  logic [44:0] xp_r, xq_r, xt_r;
  logic [2:0]  sece_r;
  logic        greye_r, doite_r;
  logic [7:0]  cve_r;
  logic [7:0]  idxe_r;
  rgb_t        rgbe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (en) ve_r <= vd_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r    <= 45'(vd_v_r) * 45'(fp_r);
      xq_r    <= 45'(vd_v_r) * 45'(fq_r);
      xt_r    <= 45'(vd_v_r) * 45'(ft_r);
      sece_r  <= secd_r;
      greye_r <= greyd_r;
      doite_r <= doitd_r;
      cve_r   <= cvd_r;
      idxe_r  <= idxd_r;
      rgbe_r  <= rgbd_r;
    end
  end

  // ---------------- stage F: round to channels and pick sector ----------------
  // Divide by 15 * 2^33 with rounding: add half the divisor, drop 33 bits, then
  // reciprocal-multiply by 15. The two floors in a row equal one floor of the whole.
  function automatic logic [7:0] to_chan(input logic [44:0] x);
    logic [45:0] sum;
    logic [12:0] t;
    logic [28:0] p;
    sum = 46'(x) + 46'hF_0000_0000;
    t   = sum[45:33];
    p   = 29'(t) * 29'(RCP_15);
    return p[26:19];
  endfunction

  logic [7:0] cp, cq, ct;
  rgb_t       hsv_rgb, rgb_f;

  always_comb begin
    cp = to_chan(xp_r);
    cq = to_chan(xq_r);
    ct = to_chan(xt_r);
    if (greye_r) begin
      hsv_rgb = '{red: cve_r, green: cve_r, blue: cve_r};
    end else begin
      unique case (sece_r)
        3'd0:    hsv_rgb = '{red: cve_r, green: ct,    blue: cp};
        3'd1:    hsv_rgb = '{red: cq,    green: cve_r, blue: cp};
        3'd2:    hsv_rgb = '{red: cp,    green: cve_r, blue: ct};
        3'd3:    hsv_rgb = '{red: cp,    green: cq,    blue: cve_r};
        3'd4:    hsv_rgb = '{red: ct,    green: cp,    blue: cve_r};
        default: hsv_rgb = '{red: cve_r, green: cp,    blue: cq};
      endcase
    end
    rgb_f = doite_r ? hsv_rgb : rgbe_r;
  end

  logic       vf_r;
  rgb_t       rgbf_r;
  logic [7:0] idxf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else if (en) vf_r <= ve_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rgbf_r <= rgb_f;
      idxf_r <= idxe_r;
    end
  end

  // ---------------- stage G: light gain and night lights ----------------
  function automatic logic [7:0] apply_gain(input logic [7:0] c, input logic [16:0] g);
    logic [25:0] p;
    p = 26'(c) * 26'(g) + 26'd32768;
    return (p[25:16] > 10'd255) ? 8'd255 : p[23:16];
  endfunction

  rgb_t out_nxt;
  logic night_on;

  always_comb begin
    night_on = (light_level_r < LIGHT_HALF) && (idxf_r >= NIGHT_BASE);
    priority if (night_on && night_vision_r) begin
      out_nxt = '{red: 8'd0, green: 8'd255, blue: 8'd0};
    end else if (night_on) begin
      out_nxt = night_color(idxf_r[1:0]);
    end else begin
      out_nxt = '{red:   apply_gain(rgbf_r.red, gain_red_r),
                  green: apply_gain(rgbf_r.green, gain_green_r),
                  blue:  apply_gain(rgbf_r.blue, gain_blue_r)};
    end
  end

  logic out_valid_r;
  rgb_t out_rgb_r;
  logic [7:0] out_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vf_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rgb_r <= out_nxt;
      out_idx_r <= idxf_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index_out = out_idx_r;
  assign out_lit_red   = out_rgb_r.red;
  assign out_lit_green = out_rgb_r.green;
  assign out_lit_blue  = out_rgb_r.blue;

  // ---------------- assertions ----------------
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while a result is stalled");

  a_divider_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
    dv_s == dv_h)
    else $error("divider lanes out of step");

  a_night_vision_green: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && night_vision_r && light_level_r < LIGHT_HALF
      && out_index_out >= NIGHT_BASE
    |-> out_lit_red == 8'd0 && out_lit_green == 8'd255 && out_lit_blue == 8'd0)
    else $error("night vision color wrong");

  a_zero_gain_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && gain_red_r == 17'd0
      && !(light_level_r < LIGHT_HALF && out_index_out >= NIGHT_BASE)
    |-> out_lit_red == 8'd0)
    else $error("zero red gain gave a nonzero channel");

endmodule

### rtl/spca_div.sv
// Pipelined restoring divider, one quotient bit per register stage, with a sideband
// that travels alongside. Depends on nothing; used by the top level for S and H.
`timescale 1ns / 1ps

module spca_div #(
  parameter int unsigned QW = 17,
  parameter int unsigned DW = 8,
  parameter int unsigned SW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [QW+DW-1:0]   num_i,
  input  logic [DW-1:0]      den_i,
  input  logic [SW-1:0]      side_i,
  output logic               vld_o,
  output logic [QW-1:0]      quot_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned NW = QW + DW;

  // The numerator must be below den * 2^QW so the top DW bits start as a remainder.
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] quot_r [QW];
  logic [NW-1:0] num_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [QW-1:0] vld_r;

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_st
      logic [DW-1:0] rem_src;
      logic [QW-1:0] quot_src;
      logic [NW-1:0] num_src;
      logic [DW-1:0] den_src;
      logic [SW-1:0] side_src;
      logic          vld_src;
      logic [DW:0]   trial;
      logic          fits;
      logic [DW-1:0] rem_nxt;

      if (k == 0) begin : g_first
        assign rem_src  = num_i[NW-1:QW];
        assign quot_src = '0;
        assign num_src  = num_i;
        assign den_src  = den_i;
        assign side_src = side_i;
        assign vld_src  = vld_i;
      end else begin : g_next
        assign rem_src  = rem_r[k-1];
        assign quot_src = quot_r[k-1];
        assign num_src  = num_r[k-1];
        assign den_src  = den_r[k-1];
        assign side_src = side_r[k-1];
        assign vld_src  = vld_r[k-1];
      end

      assign trial   = {rem_src, num_src[QW-1-k]};
      assign fits    = (trial >= {1'b0, den_src});
      assign rem_nxt = fits ? DW'(trial - {1'b0, den_src}) : trial[DW-1:0];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else if (en_i) begin
          vld_r[k] <= vld_src;
        end
      end

      always_ff @(posedge clk) begin
        if (en_i) begin
          rem_r[k]  <= rem_nxt;
          quot_r[k] <= {quot_src[QW-2:0], fits};
          num_r[k]  <= num_src;
          den_r[k]  <= den_src;
          side_r[k] <= side_src;
        end
      end
    end
  endgenerate

  assign vld_o  = vld_r[QW-1];
  assign quot_o = quot_r[QW-1];
  assign side_o = side_r[QW-1];

endmodule

### tb/spca_color_checker.sv
// Checker for the seasonal palette color adjust block: mirrors the register writes,
// predicts each adjusted entry in HSV fixed point and compares the output transactions.
// Depends on spca_pkg.
`timescale 1ns / 1ps

module spca_color_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic [7:0]                      in_entry_index,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      out_index_out,
  input  logic [7:0]                      out_lit_red,
  input  logic [7:0]                      out_lit_green,
  input  logic [7:0]                      out_lit_blue,
  input  logic                            cfg_wr_en,
  input  logic [spca_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spca_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending_count
);
  import spca_pkg::*;

  typedef struct packed {
    logic [7:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } entry_t;

  localparam longint unsigned FAC = 64'd503316480;

  season_t     cur_season;
  logic [16:0] cur_gain_r, cur_gain_g, cur_gain_b, cur_light;
  logic        cur_nv;
  entry_t      adjusted_q[$];

  assign pending_count = adjusted_q.size();

  function automatic longint unsigned ratio_round(longint unsigned x, longint unsigned num,
                                                  longint unsigned den);
    return (x * num + den / 2) / den;
  endfunction

  function automatic longint unsigned chan_of(longint unsigned v, longint unsigned f);
    longint unsigned den;
    den = FAC * 256;
    return (v * f + den / 2) / den;
  endfunction

  function automatic logic [7:0] lit(longint unsigned c, logic [16:0] gain);
    longint unsigned x;
    x = (c * gain + 32768) >> 16;
    return (x > 255) ? 8'd255 : x[7:0];
  endfunction

  function automatic entry_t adjust_entry(entry_t e);
    longint unsigned r, g, b, mx, mn, d, v, s, h, base, a, c, mag, part, sec, fr;
    longint unsigned cv, cp, cq, ct;
    longint          hs;
    bit              hok, grey, apply;
    entry_t          o;
    r = e.r; g = e.g; b = e.b;
    hok = 0; apply = 0; s = 0; h = 0;
    grey = (r == g) && (g == b);
    mx = (r > g) ? r : g; if (b > mx) mx = b;
    mn = (r < g) ? r : g; if (b < mn) mn = b;
    d = mx - mn;
    v = mx << 8;
    if (mx != 0 && d != 0) begin
      s = (d * 65536 + mx / 2) / mx;
      hok = 1;
      if (r == mx) begin
        base = 0; a = g; c = b;
      end else if (g == mx) begin
        base = 120; a = b; c = r;
      end else begin
        base = 240; a = r; c = g;
      end
      mag = (a >= c) ? a - c : c - a;
      part = (mag * 7680 + d / 2) / d;
      hs = longint'(base * 128) + ((a >= c) ? longint'(part) : -longint'(part));
      if (hs < 0) hs += 46080;
      h = hs;
    end
    case (cur_season)
      SEAS_AUTUMN: begin
        if (!(grey || g < 60 || r + g + b > 675)) begin
          apply = 1;
          if (h >= 30 * 128 && h <= 165 * 128) begin
            h = ratio_round(h, 33, 100) + 15 * 128;
            s = ratio_round(s, 6, 5);
            v = ratio_round(v, 9, 10);
          end else if (!(v * 10 > 9 * 256 && s * 10 > 9 * 65536)) begin
            s = ratio_round(s, 9, 10);
            v = ratio_round(v, 17, 20);
          end
          if (s > 65536) s = 65536;
          if (h > 255 * 128) h = 255 * 128;
        end
      end
      SEAS_WINTER: begin
        if (!grey || g < 60) begin
          apply = 1;
          if (hok && s * 5 > 65536) begin
            if (h >= 45 * 128 && h <= 150 * 128) begin
              s = 0; v = 65280;
            end
          end else begin
            v = ratio_round(v, 13, 10);
          end
          if (v > 65280) v = 65280;
        end
      end
      SEAS_SPRING: begin
        if (hok && s * 10 > 65536) begin
          apply = 1;
          if (h >= 45 * 128 && h <= 160 * 128) begin
            s = ratio_round(s, 4, 5);
            v = ratio_round(v, 6, 5);
          end
          if (v > 65280) v = 65280;
        end
      end
      default: ;
    endcase
    if (apply) begin
      if (!hok || s == 0) begin
        r = chan_of(v, FAC); g = r; b = r;
      end else begin
        sec = h / 7680; fr = h % 7680;
        cv = chan_of(v, FAC);
        cp = chan_of(v, (65536 - s) * 7680);
        cq = chan_of(v, FAC - s * fr);
        ct = chan_of(v, FAC - s * (7680 - fr));
        case (sec)
          0: begin r = cv; g = ct; b = cp; end
          1: begin r = cq; g = cv; b = cp; end
          2: begin r = cp; g = cv; b = ct; end
          3: begin r = cp; g = cq; b = cv; end
          4: begin r = ct; g = cp; b = cv; end
          default: begin r = cv; g = cp; b = cq; end
        endcase
      end
    end
    o.idx = e.idx;
    o.r = lit(r, cur_gain_r);
    o.g = lit(g, cur_gain_g);
    o.b = lit(b, cur_gain_b);
    if (cur_light < 17'd32768 && e.idx >= 8'd252) begin
      if (cur_nv) begin
        o.r = 8'd0; o.g = 8'd255; o.b = 8'd0;
      end else begin
        case (e.idx[1:0])
          2'd0: begin o.r = 8'd115; o.g = 8'd171; o.b = 8'd155; end
          2'd1: begin o.r = 8'd183; o.g = 8'd127; o.b = 8'd83; end
          2'd2: begin o.r = 8'd171; o.g = 8'd179; o.b = 8'd139; end
          default: begin o.r = 8'd171; o.g = 8'd171; o.b = 8'd171; end
        endcase
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want, logic [7:0] idx);
    $display("MISMATCH %0t entry %0d %s: got %0d expected %0d", $time, idx, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    entry_t want;
    if (!rst_n) begin
      cur_season <= SEAS_SUMMER;
      cur_gain_r <= GAIN_ONE; cur_gain_g <= GAIN_ONE; cur_gain_b <= GAIN_ONE;
      cur_light <= GAIN_ONE;
      cur_nv <= 1'b0;
      adjusted_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SEASON:       cur_season <= season_t'(cfg_data[1:0]);
          CFG_GAIN_RED:     cur_gain_r <= cfg_data;
          CFG_GAIN_GREEN:   cur_gain_g <= cfg_data;
          CFG_GAIN_BLUE:    cur_gain_b <= cfg_data;
          CFG_LIGHT_LEVEL:  cur_light <= cfg_data;
          CFG_NIGHT_VISION: cur_nv <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        adjusted_q.push_back(adjust_entry('{in_entry_index, in_red, in_green, in_blue}));
      if (out_valid && out_ready) begin
        if (adjusted_q.size() == 0) begin
          $display("UNEXPECTED %0t result for entry %0d", $time, out_index_out);
          fail_count++;
        end else begin
          want = adjusted_q.pop_front();
          if (out_index_out !== want.idx)
            report_mismatch("index", out_index_out, want.idx, want.idx);
          if (out_lit_red !== want.r) report_mismatch("red", out_lit_red, want.r, want.idx);
          if (out_lit_green !== want.g)
            report_mismatch("green", out_lit_green, want.g, want.idx);
          if (out_lit_blue !== want.b) report_mismatch("blue", out_lit_blue, want.b, want.idx);
        end
      end
    end
  end

endmodule

### tb/tb_seasonal_palette_color_adjust.sv
// Testbench top for the seasonal palette color adjust block: drives register phases and
// palette entries with bursty traffic and receiver stalls; spca_color_checker judges.
// Depends on spca_pkg, the block and spca_color_checker.
`timescale 1ns / 1ps

module tb_seasonal_palette_color_adjust;
  import spca_pkg::*;

  localparam int RUN_LIMIT = 400000;

  logic        clk, rst_n;
  logic        in_valid, in_ready;
  logic [7:0]  in_entry_index, in_red, in_green, in_blue;
  logic        out_valid, out_ready;
  logic [7:0]  out_index_out, out_lit_red, out_lit_green, out_lit_blue;
  logic        cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int          fail_count, pending_count, cycle_count;
  bit          stall_free;

  seasonal_palette_color_adjust DUT (.*);

  spca_color_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver stalls in runs: some windows never stall, others stall often.
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b1;
    else if (stall_free) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= 35);
  end
  always @(posedge clk) if ($urandom_range(0, 63) == 0) stall_free <= ~stall_free;

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (pending_count != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_phase(season_t s, logic [16:0] gr, logic [16:0] gg, logic [16:0] gb,
                           logic [16:0] lvl, logic nv);
    drain();
    write_reg(CFG_SEASON, CFG_DATA_W'(s));
    write_reg(CFG_GAIN_RED, gr);
    write_reg(CFG_GAIN_GREEN, gg);
    write_reg(CFG_GAIN_BLUE, gb);
    write_reg(CFG_LIGHT_LEVEL, lvl);
    write_reg(CFG_NIGHT_VISION, CFG_DATA_W'(nv));
  endtask

  task automatic send_entry(logic [7:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_valid <= 1'b1;
    in_entry_index <= idx; in_red <= r; in_green <= g; in_blue <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Random entries biased toward greens, greys and light entries in bursts.
  task automatic random_burst(int count);
    int left, burst, k;
    logic [7:0] r, g, b, idx, m;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      for (k = 0; k < burst && left > 0; k++) begin
        r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
        idx = ($urandom_range(0, 4) == 0) ? 8'(252 + $urandom_range(0, 3)) : 8'($urandom);
        case ($urandom_range(0, 5))
          0: begin m = 8'($urandom); r = m; g = m; b = m; end
          1: begin
            g = 8'($urandom_range(100, 255));
            r = 8'($urandom_range(0, g));
            b = 8'($urandom_range(0, g));
          end
          2: g = 8'($urandom_range(0, 70));
          default: ;
        endcase
        send_entry(idx, r, g, b);
        left--;
      end
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic directed_set();
    send_entry(8'd0, 8'd0, 8'd0, 8'd0);
    send_entry(8'd255, 8'd255, 8'd255, 8'd255);
    send_entry(8'd1, 8'd128, 8'd128, 8'd128);
    send_entry(8'd2, 8'd30, 8'd30, 8'd30);
    send_entry(8'd3, 8'd255, 8'd0, 8'd0);
    send_entry(8'd4, 8'd0, 8'd255, 8'd0);
    send_entry(8'd5, 8'd0, 8'd0, 8'd255);
    send_entry(8'd6, 8'd255, 8'd255, 8'd0);
    send_entry(8'd7, 8'd0, 8'd255, 8'd255);
    send_entry(8'd8, 8'd255, 8'd0, 8'd255);
    send_entry(8'd9, 8'd80, 8'd160, 8'd40);
    send_entry(8'd10, 8'd200, 8'd100, 8'd50);
    send_entry(8'd11, 8'd250, 8'd240, 8'd235);
    send_entry(8'd12, 8'd100, 8'd110, 8'd105);
    send_entry(8'd252, 8'd10, 8'd200, 8'd30);
    send_entry(8'd253, 8'd170, 8'd85, 8'd0);
    send_entry(8'd254, 8'd1, 8'd2, 8'd3);
    send_entry(8'd255, 8'd254, 8'd253, 8'd1);
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cycle_count = 0;
    stall_free = 1'b0;
    in_valid = 1'b0;
    in_entry_index = '0; in_red = '0; in_green = '0; in_blue = '0;
    cfg_wr_en = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_set();
    random_burst(150);
    set_phase(SEAS_AUTUMN, 17'd65536, 17'd65536, 17'd65536, 17'd65536, 1'b0);
    directed_set();
    random_burst(300);
    set_phase(SEAS_WINTER, 17'd0, 17'd65535, 17'd131071, 17'd32767, 1'b0);
    directed_set();
    random_burst(300);
    set_phase(SEAS_SPRING, 17'd98304, 17'd40000, 17'd65536, 17'd0, 1'b1);
    directed_set();
    random_burst(300);
    set_phase(SEAS_SUMMER, 17'd1, 17'd131071, 17'd0, 17'd32768, 1'b1);
    random_burst(200);
    for (int p = 0; p < 4; p++) begin
      set_phase(season_t'($urandom_range(0, 3)), 17'($urandom_range(0, 131071)),
                17'($urandom_range(0, 131071)), 17'($urandom_range(0, 131071)),
                17'($urandom_range(0, 65536)), 1'($urandom_range(0, 1)));
      random_burst(150);
    end
    in_valid <= 1'b0;
    drain();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
rtl/spca_pkg.sv
rtl/spca_div.sv
rtl/seasonal_palette_color_adjust.sv
tb/spca_color_checker.sv
tb/tb_seasonal_palette_color_adjust.sv
